// File: rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int CAP_W = 17;
  localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;
  localparam int COUNT_BITS_DEFAULT = 17;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] BYTE_ASCII_END = 8'h80;
  localparam logic [7:0] LEAD_MIN = 8'hC2;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD_MAX = 8'hF4;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] CONT_LOW = 8'h80;
  localparam logic [7:0] CONT_HIGH = 8'hBF;
  localparam logic [7:0] CONT_LOW_E0 = 8'hA0;
  localparam logic [7:0] CONT_HIGH_ED = 8'h9F;
  localparam logic [7:0] CONT_LOW_F0 = 8'h90;
  localparam logic [7:0] CONT_HIGH_F4 = 8'h8F;
  localparam logic [10:0] PLANE1_BASE = 11'd64;
  localparam logic [15:0] SURR_HIGH = 16'hD800;
  localparam logic [15:0] SURR_LOW = 16'hDC00;

  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        two;
    logic        eot;
    logic        fail;
  } job_t;

endpackage

// File: rtl/utf8_to_utf16_decoder_top.sv
`timescale 1ns / 1ps
// A byte's first unit passes through the job queue and then the output
// register before it is presented.
// Throughput: one byte per cycle; a surrogate pair takes two output items,
// absorbed by the job queue between the decoder and the emitter.
// Input stalls only when the job queue is full.
// Reset (rst, synchronous): clears the decoder, the queue and the output
// register, and sets the capacity to 4096 units.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// Streams UTF-8 bytes of zero-terminated strings and emits UTF-16 code units.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top
  import u8u16_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,     // out_capacity
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // text_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // code_unit[15:0], item_last[16], zero
  output logic             m_axis_tlast,  // end_of_text
  output logic             m_axis_tuser   // failed
);

  job_t        push_job, head_job;
  logic        push, pop, full, empty;
  logic [15:0] code_unit;
  logic        item_last;

  u8u16_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  u8u16_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .pop     (pop),
    .head_job(head_job),
    .empty   (empty)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (empty),
    .q_job      (head_job),
    .q_pop      (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .code_unit  (code_unit),
    .end_of_text(m_axis_tlast),
    .failed     (m_axis_tuser),
    .item_last  (item_last)
  );

  assign m_axis_tdata = {7'b0, item_last, code_unit};

endmodule

// File: rtl/u8u16_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: validates each byte, tracks the sequence and capacity, and
// queues the code units that the byte produces.
// ----------------------------------------------------------------------------
module u8u16_front
  import u8u16_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             full,
  output logic             push,
  output job_t             job
);

  localparam int CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

  logic [CAP_W-1:0]      capacity;
  logic [1:0]            bytes_exp, bytes_exp_next;
  logic [20:0]           acc, acc_next;
  logic [7:0]            low_bound, low_bound_next;
  logic [7:0]            high_bound, high_bound_next;
  logic [COUNT_BITS-1:0] units, units_next;
  logic                  skipping, skipping_next;

  logic [CAP_W-1:0]      limit;
  logic [CMP_W-1:0]      units_ext, limit_ext;
  logic [COUNT_BITS:0]   sum1, sum2;
  logic [COUNT_BITS-1:0] bump1, bump2;
  logic [1:0]            be_dec;
  logic [20:0]           acc_new;
  logic [9:0]            high10;
  logic                  fail;

  assign in_ready = !full;
  assign limit = (capacity == '0) ? '0 : capacity - 1'b1;
  assign units_ext = CMP_W'(units);
  assign limit_ext = CMP_W'(limit);
  assign sum1 = {1'b0, units} + (COUNT_BITS + 1)'(1);
  assign sum2 = {1'b0, units} + (COUNT_BITS + 1)'(2);
  assign bump1 = sum1[COUNT_BITS] ? '1 : sum1[COUNT_BITS-1:0];
  assign bump2 = sum2[COUNT_BITS] ? '1 : sum2[COUNT_BITS-1:0];
  assign be_dec = bytes_exp - 2'd1;
  assign high10 = 10'(acc_new[20:10] - PLANE1_BASE);

  always_comb begin
    unique case (be_dec)
      2'd2: acc_new = acc | {3'b0, in_byte[5:0], 12'b0};
      2'd1: acc_new = acc | {9'b0, in_byte[5:0], 6'b0};
      default: acc_new = acc | {15'b0, in_byte[5:0]};
    endcase
  end

  always_comb begin
    bytes_exp_next = bytes_exp;
    acc_next = acc;
    low_bound_next = low_bound;
    high_bound_next = high_bound;
    units_next = units;
    skipping_next = skipping;
    push = 1'b0;
    job = '0;
    fail = 1'b0;
    if (in_valid && in_ready) begin
      if (skipping) begin
        if (in_byte == 8'h00) begin
          skipping_next = 1'b0;
        end
      end else if (bytes_exp == 2'd0) begin
        if (in_byte == 8'h00) begin
          units_next = '0;
          push = 1'b1;
          job.eot = 1'b1;
        end else if (units_ext >= limit_ext) begin
          fail = 1'b1;
        end else if (in_byte < BYTE_ASCII_END) begin
          units_next = bump1;
          push = 1'b1;
          job.unit0 = {8'b0, in_byte};
        end else if (in_byte < LEAD_MIN || in_byte > LEAD_MAX) begin
          fail = 1'b1;
        end else begin
          low_bound_next = CONT_LOW;
          high_bound_next = CONT_HIGH;
          if (in_byte < LEAD3_MIN) begin
            acc_next = {10'b0, in_byte[4:0], 6'b0};
            bytes_exp_next = 2'd1;
          end else if (in_byte < LEAD4_MIN) begin
            acc_next = {5'b0, in_byte[3:0], 12'b0};
            bytes_exp_next = 2'd2;
            if (in_byte == LEAD3_MIN) begin
              low_bound_next = CONT_LOW_E0;
            end
            if (in_byte == LEAD_ED) begin
              high_bound_next = CONT_HIGH_ED;
            end
          end else begin
            acc_next = {in_byte[2:0], 18'b0};
            bytes_exp_next = 2'd3;
            if (in_byte == LEAD4_MIN) begin
              low_bound_next = CONT_LOW_F0;
            end
            if (in_byte == LEAD_MAX) begin
              high_bound_next = CONT_HIGH_F4;
            end
          end
        end
      end else if (in_byte < low_bound || in_byte > high_bound) begin
        fail = 1'b1;
      end else begin
        bytes_exp_next = be_dec;
        acc_next = acc_new;
        low_bound_next = CONT_LOW;
        high_bound_next = CONT_HIGH;
        if (be_dec == 2'd0) begin
          if (acc_new[20:16] != 5'd0) begin
            if (units_ext + CMP_W'(2) > limit_ext) begin
              fail = 1'b1;
            end else begin
              units_next = bump2;
              acc_next = '0;
              push = 1'b1;
              job.unit0 = SURR_HIGH | {6'b0, high10};
              job.unit1 = SURR_LOW | {6'b0, acc_new[9:0]};
              job.two = 1'b1;
            end
          end else begin
            units_next = bump1;
            acc_next = '0;
            push = 1'b1;
            job.unit0 = acc_new[15:0];
          end
        end
      end
      if (fail) begin
        bytes_exp_next = 2'd0;
        acc_next = '0;
        low_bound_next = CONT_LOW;
        high_bound_next = CONT_HIGH;
        units_next = '0;
        skipping_next = (in_byte != 8'h00);
        push = 1'b1;
        job = '0;
        job.eot = 1'b1;
        job.fail = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      bytes_exp <= 2'd0;
      acc <= '0;
      low_bound <= CONT_LOW;
      high_bound <= CONT_HIGH;
      units <= '0;
      skipping <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      bytes_exp <= bytes_exp_next;
      acc <= acc_next;
      low_bound <= low_bound_next;
      high_bound <= high_bound_next;
      units <= units_next;
      skipping <= skipping_next;
    end
  end

`ifndef SYNTHESIS
  a_skip_outside_seq: assert property (@(posedge clk) disable iff (rst)
    skipping |-> (bytes_exp == 2'd0))
    else $error("skip mode set inside a multibyte sequence");
`endif

endmodule

// File: rtl/u8u16_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_queue
// Small register queue of decoded jobs between the decoder and the emitter.
// ----------------------------------------------------------------------------
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head_job = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("job written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("job read from an empty queue");
`endif

endmodule

// File: rtl/u8u16_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_back
// Emitter: drains queued jobs and presents one code unit per output item,
// splitting a surrogate pair over two items.
// ----------------------------------------------------------------------------
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        end_of_text,
  output logic        failed,
  output logic        item_last
);

  logic        pend_valid;
  logic [15:0] pend_unit;
  logic        can_load;

  assign can_load = !out_valid || out_ready;
  assign q_pop = can_load && !pend_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (can_load) begin
      if (pend_valid) begin
        out_valid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        pend_valid <= q_job.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_valid) begin
        code_unit <= pend_unit;
        end_of_text <= 1'b0;
        failed <= 1'b0;
        item_last <= 1'b1;
      end else if (!q_empty) begin
        code_unit <= q_job.unit0;
        end_of_text <= q_job.eot;
        failed <= q_job.fail;
        item_last <= !q_job.two;
        pend_unit <= q_job.unit1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid && !item_last)
    else $error("second surrogate pending without its first unit shown");
  a_fail_ends_text: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> end_of_text && item_last && (code_unit == 16'h0000))
    else $error("malformed failure item");
`endif

endmodule
